[src/nbcp_pkg.sv]
// ----------------------------------------------------------------------------
// nbcp_pkg
// shared constants, codes and types of the nested block cycle profiler
// ----------------------------------------------------------------------------
package nbcp_pkg;

    localparam int MAX_TIMERS  = 63;
    localparam int STACK_DEPTH = 16;
    localparam int TABLE_SIZE  = MAX_TIMERS + 1;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 6;
    localparam int WORD_W   = 64;
    localparam int CALLS_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);
    localparam int SP_W     = $clog2(STACK_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 3'd0,
        CMD_OPEN  = 3'd1,
        CMD_CLOSE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_READ,
        S_POP,
        S_PAR,
        S_TIM
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0]  self_cycles;
        logic [WORD_W-1:0]  full_cycles;
        logic [WORD_W-1:0]  byte_total;
        logic [CALLS_W-1:0] close_count;
    } t_entry;

    typedef struct packed {
        logic [ID_W-1:0]   parent;
        logic [ID_W-1:0]   timer;
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] carry;
    } t_frame;

    typedef struct packed {
        logic            rd_en;
        logic [ID_W-1:0] rd_addr;
        logic            wr_en;
        logic [ID_W-1:0] wr_addr;
        t_entry          wr_data;
        logic            clear;
    } t_tbl_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     assigned_id;
        logic [WORD_W-1:0]   self_cycles;
        logic [WORD_W-1:0]   full_cycles;
        logic [WORD_W-1:0]   byte_total;
        logic [CALLS_W-1:0]  close_count;
        logic [WORD_W-1:0]   total_cycles;
    } t_result;

    function automatic logic [ID_W-1:0] sat_id(input logic [ID_W-1:0] raw);
        sat_id = (raw > ID_W'(MAX_TIMERS)) ? ID_W'(MAX_TIMERS) : raw;
    endfunction

endpackage

[src/nbcp_if.sv]
// ----------------------------------------------------------------------------
// nbcp channel interfaces
// command channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface nbcp_in_if;
    logic                         valid;
    logic                         ready;
    logic [nbcp_pkg::CMD_W-1:0]   command;
    logic [nbcp_pkg::ID_W-1:0]    timer_sel;
    logic [nbcp_pkg::WORD_W-1:0]  byte_count;
    logic [nbcp_pkg::WORD_W-1:0]  timestamp;

    modport source (output valid, command, timer_sel, byte_count, timestamp, input ready);
    modport sink   (input valid, command, timer_sel, byte_count, timestamp, output ready);
endinterface

interface nbcp_out_if;
    logic                          valid;
    logic                          ready;
    logic [nbcp_pkg::STATUS_W-1:0] status;
    logic [nbcp_pkg::ID_W-1:0]     assigned_id;
    logic [nbcp_pkg::WORD_W-1:0]   self_cycles;
    logic [nbcp_pkg::WORD_W-1:0]   full_cycles;
    logic [nbcp_pkg::WORD_W-1:0]   byte_total;
    logic [nbcp_pkg::CALLS_W-1:0]  close_count;
    logic [nbcp_pkg::WORD_W-1:0]   total_cycles;

    modport source (output valid, status, assigned_id, self_cycles, full_cycles,
                    byte_total, close_count, total_cycles, input ready);
    modport sink   (input valid, status, assigned_id, self_cycles, full_cycles,
                    byte_total, close_count, total_cycles, output ready);
endinterface

[src/nbcp_table.sv]
// ----------------------------------------------------------------------------
// nbcp_table
// timer table memory, one read and one write port, registered read data,
// per-entry valid flags so that reset and clear empty it by dropping every flag together
// ----------------------------------------------------------------------------
module nbcp_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nbcp_pkg::t_tbl_req i_req,
    output nbcp_pkg::t_entry   o_rd_data
);

    nbcp_pkg::t_entry                      r_mem [nbcp_pkg::TABLE_SIZE];
    logic [nbcp_pkg::TABLE_SIZE-1:0]       r_valid;
    nbcp_pkg::t_entry                      r_rd_q;
    logic                                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_q <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign o_rd_data = r_rd_vld ? r_rd_q : '0;

endmodule

[src/nested_block_cycle_profiler.sv]
// ----------------------------------------------------------------------------
// nested_block_cycle_profiler
// answers: allocate, clear, overflow and underflow answer at the accepting edge;
//          open and read answer from S_OPEN or S_READ, close from S_TIM after S_POP
//          (stack read) and S_PAR (parent read-modify-write), S_TIM doing the timer
//          read-modify-write; one table port, commands wait for S_IDLE and free output
// reset: synchronous, active low; table emptied at once through valid flags
// ----------------------------------------------------------------------------
module nested_block_cycle_profiler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbcp_in_if.sink     i_in,
    nbcp_out_if.source  o_out
);

    nbcp_pkg::t_state                    r_state, n_state;
    logic [nbcp_pkg::ID_W-1:0]           r_id, n_id;
    logic [nbcp_pkg::WORD_W-1:0]         r_bytes, n_bytes;
    logic [nbcp_pkg::WORD_W-1:0]         r_now, n_now;
    logic [nbcp_pkg::ID_W-1:0]           r_ids, n_ids;
    logic [nbcp_pkg::ID_W-1:0]           r_current, n_current;
    logic [nbcp_pkg::DEPTH_W-1:0]        r_depth, n_depth;
    logic [nbcp_pkg::WORD_W-1:0]         r_clear_stamp, n_clear_stamp;
    logic [nbcp_pkg::WORD_W-1:0]         r_elapsed, n_elapsed;
    logic [nbcp_pkg::ID_W-1:0]           r_par, n_par;
    logic [nbcp_pkg::ID_W-1:0]           r_tim, n_tim;
    logic [nbcp_pkg::WORD_W-1:0]         r_carry, n_carry;
    logic                                r_fwd, n_fwd;
    nbcp_pkg::t_entry                    r_fwd_entry, n_fwd_entry;
    nbcp_pkg::t_result                   r_res, n_res;
    logic                                r_o_valid;

    nbcp_pkg::t_frame                    r_stk [nbcp_pkg::STACK_DEPTH];
    nbcp_pkg::t_frame                    r_stk_q;
    logic                                stk_rd_en;
    logic [nbcp_pkg::SP_W-1:0]           stk_rd_addr;
    logic                                stk_wr_en;
    logic [nbcp_pkg::SP_W-1:0]           stk_wr_addr;
    nbcp_pkg::t_frame                    stk_wr_data;

    nbcp_pkg::t_tbl_req                  tbl_req;
    nbcp_pkg::t_entry                    tbl_q;
    nbcp_pkg::t_entry                    upd;
    logic                                in_fire;
    logic                                o_load;
    logic [nbcp_pkg::ID_W-1:0]           in_id;

    nbcp_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .o_rd_data (tbl_q)
    );

    assign i_in.ready = (r_state == nbcp_pkg::S_IDLE) && (!r_o_valid || o_out.ready);
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_id      = nbcp_pkg::sat_id(i_in.timer_sel);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nbcp_pkg::S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.command)
                        nbcp_pkg::CMD_OPEN: begin
                            if (r_depth < nbcp_pkg::DEPTH_W'(nbcp_pkg::STACK_DEPTH)) begin
                                n_state = nbcp_pkg::S_OPEN;
                            end
                        end
                        nbcp_pkg::CMD_CLOSE: begin
                            if (r_depth != '0) begin
                                n_state = nbcp_pkg::S_POP;
                            end
                        end
                        nbcp_pkg::CMD_READ: n_state = nbcp_pkg::S_READ;
                        default:            n_state = nbcp_pkg::S_IDLE;
                    endcase
                end
            end
            nbcp_pkg::S_OPEN: n_state = nbcp_pkg::S_IDLE;
            nbcp_pkg::S_READ: n_state = nbcp_pkg::S_IDLE;
            nbcp_pkg::S_POP:  n_state = nbcp_pkg::S_PAR;
            nbcp_pkg::S_PAR:  n_state = nbcp_pkg::S_TIM;
            nbcp_pkg::S_TIM:  n_state = nbcp_pkg::S_IDLE;
            default:          n_state = nbcp_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_id          = r_id;
        n_bytes       = r_bytes;
        n_now         = r_now;
        n_ids         = r_ids;
        n_current     = r_current;
        n_depth       = r_depth;
        n_clear_stamp = r_clear_stamp;
        n_elapsed     = r_elapsed;
        n_par         = r_par;
        n_tim         = r_tim;
        n_carry       = r_carry;
        n_fwd         = r_fwd;
        n_fwd_entry   = r_fwd_entry;
        n_res         = '0;
        o_load        = 1'b0;
        tbl_req       = '0;
        stk_rd_en     = 1'b0;
        stk_rd_addr   = nbcp_pkg::SP_W'(r_depth - nbcp_pkg::DEPTH_W'(1));
        stk_wr_en     = 1'b0;
        stk_wr_addr   = r_depth[nbcp_pkg::SP_W-1:0];
        stk_wr_data   = '0;
        upd           = tbl_q;

        unique case (r_state)
            nbcp_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_id    = in_id;
                    n_bytes = i_in.byte_count;
                    n_now   = i_in.timestamp;
                    unique case (i_in.command)
                        nbcp_pkg::CMD_ALLOC: begin
                            o_load = 1'b1;
                            if (r_ids < nbcp_pkg::ID_W'(nbcp_pkg::MAX_TIMERS)) begin
                                n_ids             = r_ids + nbcp_pkg::ID_W'(1);
                                n_res.assigned_id = r_ids + nbcp_pkg::ID_W'(1);
                            end else begin
                                n_res.assigned_id = nbcp_pkg::ID_W'(nbcp_pkg::MAX_TIMERS);
                            end
                        end
                        nbcp_pkg::CMD_OPEN: begin
                            if (r_depth < nbcp_pkg::DEPTH_W'(nbcp_pkg::STACK_DEPTH)) begin
                                tbl_req.rd_en   = 1'b1;
                                tbl_req.rd_addr = in_id;
                            end else begin
                                o_load       = 1'b1;
                                n_res.status = nbcp_pkg::ST_OVERFLOW;
                            end
                        end
                        nbcp_pkg::CMD_CLOSE: begin
                            if (r_depth != '0) begin
                                stk_rd_en = 1'b1;
                            end else begin
                                o_load       = 1'b1;
                                n_res.status = nbcp_pkg::ST_UNDERFLOW;
                            end
                        end
                        nbcp_pkg::CMD_READ: begin
                            tbl_req.rd_en   = 1'b1;
                            tbl_req.rd_addr = in_id;
                        end
                        nbcp_pkg::CMD_CLEAR: begin
                            o_load        = 1'b1;
                            tbl_req.clear = 1'b1;
                            n_ids         = '0;
                            n_current     = '0;
                            n_depth       = '0;
                            n_clear_stamp = i_in.timestamp;
                        end
                        default: begin
                            o_load = 1'b1;
                        end
                    endcase
                end
            end
            nbcp_pkg::S_OPEN: begin
                stk_wr_en          = 1'b1;
                stk_wr_data.parent = r_current;
                stk_wr_data.timer  = r_id;
                stk_wr_data.start  = r_now;
                stk_wr_data.carry  = tbl_q.full_cycles;
                upd.byte_total     = tbl_q.byte_total + r_bytes;
                tbl_req.wr_en      = 1'b1;
                tbl_req.wr_addr    = r_id;
                tbl_req.wr_data    = upd;
                n_depth            = r_depth + nbcp_pkg::DEPTH_W'(1);
                n_current          = r_id;
                o_load             = 1'b1;
            end
            nbcp_pkg::S_READ: begin
                o_load             = 1'b1;
                n_res.self_cycles  = tbl_q.self_cycles;
                n_res.full_cycles  = tbl_q.full_cycles;
                n_res.byte_total   = tbl_q.byte_total;
                n_res.close_count  = tbl_q.close_count;
                n_res.total_cycles = r_now - r_clear_stamp;
            end
            nbcp_pkg::S_POP: begin
                n_par           = r_stk_q.parent;
                n_tim           = r_stk_q.timer;
                n_carry         = r_stk_q.carry;
                n_elapsed       = r_now - r_stk_q.start;
                n_depth         = r_depth - nbcp_pkg::DEPTH_W'(1);
                n_current       = r_stk_q.parent;
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = r_stk_q.parent;
            end
            nbcp_pkg::S_PAR: begin
                upd.self_cycles = tbl_q.self_cycles - r_elapsed;
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = r_par;
                tbl_req.wr_data = upd;
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = r_tim;
                // timer read races the parent write when both are the same entry
                n_fwd           = (r_par == r_tim);
                n_fwd_entry     = upd;
            end
            nbcp_pkg::S_TIM: begin
                upd             = r_fwd ? r_fwd_entry : tbl_q;
                upd.self_cycles = upd.self_cycles + r_elapsed;
                upd.full_cycles = r_carry + r_elapsed;
                upd.close_count = upd.close_count + nbcp_pkg::CALLS_W'(1);
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = r_tim;
                tbl_req.wr_data = upd;
                o_load          = 1'b1;
            end
            default: begin
                o_load = 1'b0;
            end
        endcase
    end

    // open-block stack memory
    always_ff @(posedge i_clk) begin
        if (stk_wr_en) begin
            r_stk[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en) begin
            r_stk_q <= r_stk[stk_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= nbcp_pkg::S_IDLE;
            r_ids         <= '0;
            r_current     <= '0;
            r_depth       <= '0;
            r_clear_stamp <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_ids         <= n_ids;
            r_current     <= n_current;
            r_depth       <= n_depth;
            r_clear_stamp <= n_clear_stamp;
            if (o_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id        <= n_id;
        r_bytes     <= n_bytes;
        r_now       <= n_now;
        r_elapsed   <= n_elapsed;
        r_par       <= n_par;
        r_tim       <= n_tim;
        r_carry     <= n_carry;
        r_fwd       <= n_fwd;
        r_fwd_entry <= n_fwd_entry;
        if (o_load) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.status       = r_res.status;
    assign o_out.assigned_id  = r_res.assigned_id;
    assign o_out.self_cycles  = r_res.self_cycles;
    assign o_out.full_cycles  = r_res.full_cycles;
    assign o_out.byte_total   = r_res.byte_total;
    assign o_out.close_count  = r_res.close_count;
    assign o_out.total_cycles = r_res.total_cycles;

endmodule

[bench/nbcp_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nbcp_tb_pkg
// profile table predictor and result scoreboard for the nested block profiler
// ----------------------------------------------------------------------------
package nbcp_tb_pkg;

    import nbcp_pkg::*;

    class profiler_scoreboard;

        logic [WORD_W-1:0]  self_cyc [TABLE_SIZE];
        logic [WORD_W-1:0]  full_cyc [TABLE_SIZE];
        logic [WORD_W-1:0]  byte_sum [TABLE_SIZE];
        logic [CALLS_W-1:0] call_cnt [TABLE_SIZE];
        int unsigned        ids_used;
        logic [ID_W-1:0]    cur_timer;
        t_frame             frames [STACK_DEPTH];
        int unsigned        depth;
        logic [WORD_W-1:0]  clear_at;
        t_result            expected_q [$];
        int                 errors;

        function new();
            errors = 0;
            wipe('0);
        endfunction

        function void wipe(logic [WORD_W-1:0] stamp);
            foreach (self_cyc[i]) begin
                self_cyc[i] = '0;
                full_cyc[i] = '0;
                byte_sum[i] = '0;
                call_cnt[i] = '0;
            end
            ids_used  = 0;
            cur_timer = '0;
            depth     = 0;
            clear_at  = stamp;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_transaction(t_cmd cmd, logic [ID_W-1:0] raw_id,
                                       logic [WORD_W-1:0] bytes, logic [WORD_W-1:0] stamp);
            t_result           r;
            t_frame            f;
            logic [ID_W-1:0]   id;
            logic [WORD_W-1:0] elapsed;
            r  = '0;
            id = (raw_id > ID_W'(MAX_TIMERS)) ? ID_W'(MAX_TIMERS) : raw_id;
            case (cmd)
                CMD_ALLOC: begin
                    if (ids_used < MAX_TIMERS) ids_used++;
                    r.assigned_id = ID_W'(ids_used);
                end
                CMD_OPEN: begin
                    if (depth >= STACK_DEPTH) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        frames[depth] = '{parent: cur_timer, timer: id, start: stamp,
                                          carry: full_cyc[id]};
                        depth++;
                        byte_sum[id] += bytes;
                        cur_timer = id;
                    end
                end
                CMD_CLOSE: begin
                    if (depth == 0) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        depth--;
                        f = frames[depth];
                        elapsed = stamp - f.start;
                        cur_timer = f.parent;
                        // parent first, so a block nested in itself cancels out
                        self_cyc[f.parent] -= elapsed;
                        self_cyc[f.timer]  += elapsed;
                        full_cyc[f.timer]   = f.carry + elapsed;
                        call_cnt[f.timer]  += 1'b1;
                    end
                end
                CMD_READ: begin
                    r.self_cycles  = self_cyc[id];
                    r.full_cycles  = full_cyc[id];
                    r.byte_total   = byte_sum[id];
                    r.close_count  = call_cnt[id];
                    r.total_cycles = stamp - clear_at;
                end
                CMD_CLEAR: wipe(stamp);
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report("result transaction with no pending expectation");
            end else begin
                want = expected_q.pop_front();
                compare_field("status",       WORD_W'(got.status),      WORD_W'(want.status));
                compare_field("assigned_id",  WORD_W'(got.assigned_id), WORD_W'(want.assigned_id));
                compare_field("self_cycles",  got.self_cycles,          want.self_cycles);
                compare_field("full_cycles",  got.full_cycles,          want.full_cycles);
                compare_field("byte_total",   got.byte_total,           want.byte_total);
                compare_field("close_count",  WORD_W'(got.close_count), WORD_W'(want.close_count));
                compare_field("total_cycles", got.total_cycles,         want.total_cycles);
            end
        endtask

    endclass

endpackage

[bench/tb_nested_block_cycle_profiler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nested_block_cycle_profiler
// drives open/close nesting, reads, allocation, clears and error cases into
// the profiler under random source gaps and sink stalls, and checks every
// result transaction against a predicted profile table
// ----------------------------------------------------------------------------
module tb_nested_block_cycle_profiler;

    import nbcp_pkg::*;
    import nbcp_tb_pkg::*;

    localparam int ITEMS      = 1500;
    localparam int TAIL_ITEMS = 200;
    localparam int LIMIT      = 500000;

    logic i_clk;
    logic i_rst_n;

    nbcp_in_if  in_ch ();
    nbcp_out_if out_ch ();

    nested_block_cycle_profiler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    profiler_scoreboard sb = new();

    int                cycle_count = 0;
    int                sent        = 0;
    bit                quiet_tail  = 1'b0;
    logic [WORD_W-1:0] now_stamp   = '0;
    t_result           got;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: stall bursts in some stretches, none in others
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && !quiet_tail && ((cycle_count / 256) % 3 != 0)
                    && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= i_rst_n;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status       = out_ch.status;
            got.assigned_id  = out_ch.assigned_id;
            got.self_cycles  = out_ch.self_cycles;
            got.full_cycles  = out_ch.full_cycles;
            got.byte_total   = out_ch.byte_total;
            got.close_count  = out_ch.close_count;
            got.total_cycles = out_ch.total_cycles;
            sb.check_result(got);
        end
    end

    function automatic logic [WORD_W-1:0] advance_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)      now_stamp += {$urandom, $urandom};
        else if (r < 6) now_stamp += WORD_W'($urandom_range(0, 2));
        else            now_stamp += WORD_W'($urandom_range(1, 40));
        return now_stamp;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 7) return ID_W'($urandom_range(0, 7));
        return ID_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [WORD_W-1:0] pick_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return WORD_W'($urandom_range(0, 4096));
        if (r < 85) return {$urandom, $urandom};
        return ~WORD_W'($urandom_range(0, 255));
    endfunction

    task automatic send_at(t_cmd cmd, logic [ID_W-1:0] id, logic [WORD_W-1:0] bytes,
                           logic [WORD_W-1:0] stamp);
        if (!quiet_tail && ((cycle_count / 300) % 3 != 1) && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.timer_sel  <= id;
        in_ch.byte_count <= bytes;
        in_ch.timestamp  <= stamp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_transaction(cmd, id, bytes, stamp);
        sent++;
        if (sent >= ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
    endtask

    task automatic send(t_cmd cmd, logic [ID_W-1:0] id);
        send_at(cmd, id, pick_bytes(), advance_stamp());
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic nest_walk(int n);
        int r;
        int open_bias;
        open_bias = $urandom_range(30, 55);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (sb.depth < STACK_DEPTH && (r < open_bias || (sb.depth == 0 && r < 70)))
                send(CMD_OPEN, pick_id());
            else if (r < 80 && sb.depth > 0)
                send(CMD_CLOSE, pick_id());
            else if (r < 93)
                send(CMD_READ, pick_id());
            else
                send(CMD_ALLOC, pick_id());
        end
    endtask

    task automatic deep_nest();
        while (sb.depth < STACK_DEPTH) send(CMD_OPEN, pick_id());
        send(CMD_OPEN, pick_id());
        send(CMD_READ, pick_id());
        while (sb.depth > 0) begin
            send(CMD_CLOSE, pick_id());
            if ($urandom_range(0, 3) == 0) send(CMD_READ, pick_id());
        end
        send(CMD_CLOSE, pick_id());
    endtask

    task automatic alloc_sweep();
        repeat (MAX_TIMERS + 3) send(CMD_ALLOC, pick_id());
        send(CMD_READ, pick_id());
    endtask

    task automatic random_noise();
        repeat ($urandom_range(3, 10))
            send(t_cmd'($urandom_range(0, 4)), ID_W'($urandom_range(0, 63)));
    endtask

    initial begin
        int kind;
        int wait_cycles;
        bit mid_hold_done;
        mid_hold_done = 1'b0;

        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.command    <= CMD_ALLOC;
        in_ch.timer_sel  <= '0;
        in_ch.byte_count <= '0;
        in_ch.timestamp  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command, error cases
        send_at(CMD_READ,  ID_W'(0),  '0, '1);
        send_at(CMD_CLOSE, ID_W'(0),  '0, 64'd5);
        send_at(CMD_CLEAR, ID_W'(63), '1, '1);
        send_at(CMD_READ,  ID_W'(63), '0, 64'd9);
        send_at(CMD_OPEN,  ID_W'(63), '1, 64'hFFFF_FFFF_FFFF_FFF0);
        send_at(CMD_OPEN,  ID_W'(63), '1, 64'hFFFF_FFFF_FFFF_FFF8);
        send_at(CMD_CLOSE, ID_W'(0),  '0, 64'h10);
        send_at(CMD_CLOSE, ID_W'(0),  '0, 64'h30);
        send_at(CMD_READ,  ID_W'(63), '0, 64'h31);
        send_at(CMD_READ,  ID_W'(0),  '0, 64'h32);
        send_at(CMD_OPEN,  ID_W'(5),  64'd100, 64'h40);
        send_at(CMD_OPEN,  ID_W'(9),  64'd1,   64'h50);
        send_at(CMD_CLOSE, ID_W'(0),  '0, 64'h50);
        send_at(CMD_OPEN,  ID_W'(9),  64'd2,   64'h58);
        send_at(CMD_CLOSE, ID_W'(0),  '0, 64'h70);
        send_at(CMD_CLOSE, ID_W'(0),  '0, 64'h90);
        send_at(CMD_READ,  ID_W'(5),  '0, 64'h91);
        send_at(CMD_READ,  ID_W'(9),  '0, 64'h92);
        send_at(CMD_ALLOC, ID_W'(42), '0, 64'h93);
        send_at(CMD_ALLOC, ID_W'(21), '0, 64'h94);
        send_at(CMD_CLEAR, ID_W'(0),  '0, '0);
        send_at(CMD_READ,  ID_W'(5),  '0, 64'h7);
        now_stamp = 64'h100;
        hold_until_drained();

        alloc_sweep();
        deep_nest();
        while (sent < ITEMS) begin
            if (!mid_hold_done && sent >= ITEMS / 2) begin
                hold_until_drained();
                mid_hold_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 70)      nest_walk($urandom_range(4, 30));
            else if (kind < 80) deep_nest();
            else if (kind < 84) alloc_sweep();
            else if (kind < 90) begin
                send(CMD_CLEAR, pick_id());
                send(CMD_READ, ID_W'(0));
                send(CMD_READ, pick_id());
            end else begin
                random_noise();
            end
        end

        in_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
src/nbcp_pkg.sv
src/nbcp_if.sv
src/nbcp_table.sv
src/nested_block_cycle_profiler.sv
bench/nbcp_tb_pkg.sv
bench/tb_nested_block_cycle_profiler.sv
